>>> src/lbe_pkg.sv
package lbe_pkg;

  localparam int VALUE_W   = 32;
  localparam int FRAC_W    = 16;
  localparam int MAX_ORDER = 8;
  localparam int NODES     = MAX_ORDER + 1;
  localparam int IDX_W     = 4;
  localparam int ORDER_W   = 4;
  localparam int DIV_NUM_W = VALUE_W + FRAC_W;
  localparam int DIV_DEN_W = VALUE_W;
  localparam int DIV_CNT_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [IDX_W-1:0]          idx_t;

  localparam value_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam value_t ONE_Q   = value_t'(1) <<< FRAC_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic store;
    idx_t idx;
    idx_t rd_addr;
    logic hold_en;
    logic q_go;
    logic use_one;
    logic node_go;
    logic node_wr;
    logic acc_one;
    logic acc_ld;
    logic mul_go;
    logic mul_nodal;
    logic interp_add;
    logic shp_wr;
    logic g_clr;
    logic g_add;
    logic out_load;
    logic out_bad;
    logic out_last;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic bad;
    idx_t n;
    logic out_busy;
  } sts_t;

  function automatic value_t sat_sum(input logic signed [VALUE_W:0] s);
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      return s[VALUE_W] ? VAL_MIN : VAL_MAX;
    end
    return value_t'(s[VALUE_W-1:0]);
  endfunction

endpackage

>>> src/lbe_in_if.sv
interface lbe_in_if;
  import lbe_pkg::*;

  logic   valid;
  logic   ready;
  logic   mode;
  idx_t   node_index;
  value_t nodal_value;
  value_t position;

  modport source(output valid, mode, node_index, nodal_value, position, input ready);
  modport sink(input valid, mode, node_index, nodal_value, position, output ready);
endinterface

>>> src/lbe_out_if.sv
interface lbe_out_if;
  import lbe_pkg::*;

  logic   valid;
  logic   ready;
  idx_t   node_number;
  value_t shape_value;
  value_t shape_gradient;
  value_t interpolated;
  logic   bad_interval;
  logic   last;

  modport source(output valid, node_number, shape_value, shape_gradient, interpolated,
                 bad_interval, last, input ready);
  modport sink(input valid, node_number, shape_value, shape_gradient, interpolated,
               bad_interval, last, output ready);
endinterface

>>> src/lbe_div.sv
module lbe_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [lbe_pkg::DIV_NUM_W-1:0] num,
  input  logic [lbe_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [lbe_pkg::DIV_NUM_W-1:0] quo
);
  import lbe_pkg::*;

  // Restoring division, one quotient bit per cycle.
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] q_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    fits    = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1));
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      den_r <= den;
      q_r   <= num;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      q_r   <= {q_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

>>> src/lbe_ctrl.sv
module lbe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_ready,
  output lbe_pkg::ctl_t ctl,
  input  lbe_pkg::sts_t sts
);
  import lbe_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_EMITBAD = 5'd1;
  localparam logic [4:0] ST_NODE    = 5'd2;
  localparam logic [4:0] ST_NWAIT   = 5'd3;
  localparam logic [4:0] ST_SH_INIT = 5'd4;
  localparam logic [4:0] ST_SH_SEL  = 5'd5;
  localparam logic [4:0] ST_SH_INT1 = 5'd6;
  localparam logic [4:0] ST_SH_INT2 = 5'd7;
  localparam logic [4:0] ST_SH_INT3 = 5'd8;
  localparam logic [4:0] ST_GJ_INIT = 5'd9;
  localparam logic [4:0] ST_GI_SEL  = 5'd10;
  localparam logic [4:0] ST_GR_SEL  = 5'd11;
  localparam logic [4:0] ST_EMIT    = 5'd12;
  localparam logic [4:0] ST_FRD1    = 5'd13;
  localparam logic [4:0] ST_FRD2    = 5'd14;
  localparam logic [4:0] ST_FGO     = 5'd15;
  localparam logic [4:0] ST_FWAIT   = 5'd16;
  localparam logic [4:0] ST_FM1     = 5'd17;
  localparam logic [4:0] ST_FM2     = 5'd18;
  localparam logic [4:0] ST_FM3     = 5'd19;

  localparam logic [1:0] RET_SH = 2'd0;
  localparam logic [1:0] RET_G1 = 2'd1;
  localparam logic [1:0] RET_G2 = 2'd2;

  logic [4:0] st_r, st_nxt;
  idx_t       o_r, o_nxt;
  idx_t       p_r, p_nxt;
  idx_t       r_r, r_nxt;
  logic [1:0] ret_r, ret_nxt;
  idx_t       t_sel;

  always_comb begin
    st_nxt   = st_r;
    o_nxt    = o_r;
    p_nxt    = p_r;
    r_nxt    = r_r;
    ret_nxt  = ret_r;
    ctl      = '0;
    ctl.idx  = o_r;
    ctl.rd_addr = o_r;
    in_ready = 1'b0;
    t_sel    = (ret_r == RET_G2) ? r_r : p_r;

    case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_mode) begin
            ctl.store = 1'b1;
          end else begin
            ctl.start = 1'b1;
            o_nxt     = '0;
            st_nxt    = sts.bad ? ST_EMITBAD : ST_NODE;
          end
        end
      end
      ST_EMITBAD: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.out_bad  = 1'b1;
          ctl.out_last = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      ST_NODE: begin
        ctl.node_go = 1'b1;
        st_nxt      = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (sts.div_done) begin
          ctl.node_wr = 1'b1;
          if (o_r == sts.n) begin
            o_nxt  = '0;
            st_nxt = ST_SH_INIT;
          end else begin
            o_nxt  = o_r + idx_t'(1);
            st_nxt = ST_NODE;
          end
        end
      end
      ST_SH_INIT: begin
        ctl.acc_one = 1'b1;
        p_nxt       = '0;
        st_nxt      = ST_SH_SEL;
      end
      ST_SH_SEL: begin
        if (p_r > sts.n) begin
          st_nxt = ST_SH_INT1;
        end else if (p_r == o_r) begin
          p_nxt = p_r + idx_t'(1);
        end else begin
          ret_nxt = RET_SH;
          st_nxt  = ST_FRD1;
        end
      end
      ST_SH_INT1: begin
        ctl.mul_go    = 1'b1;
        ctl.mul_nodal = 1'b1;
        ctl.shp_wr    = 1'b1;
        st_nxt        = ST_SH_INT2;
      end
      ST_SH_INT2: begin
        st_nxt = ST_SH_INT3;
      end
      ST_SH_INT3: begin
        ctl.interp_add = 1'b1;
        if (o_r == sts.n) begin
          o_nxt  = '0;
          st_nxt = ST_GJ_INIT;
        end else begin
          o_nxt  = o_r + idx_t'(1);
          st_nxt = ST_SH_INIT;
        end
      end
      ST_GJ_INIT: begin
        ctl.g_clr = 1'b1;
        p_nxt     = '0;
        st_nxt    = ST_GI_SEL;
      end
      ST_GI_SEL: begin
        if (p_r > sts.n) begin
          st_nxt = ST_EMIT;
        end else if (p_r == o_r) begin
          p_nxt = p_r + idx_t'(1);
        end else begin
          ctl.acc_one = 1'b1;
          ret_nxt     = RET_G1;
          st_nxt      = ST_FRD1;
        end
      end
      ST_GR_SEL: begin
        if (r_r > sts.n) begin
          ctl.g_add = 1'b1;
          p_nxt     = p_r + idx_t'(1);
          st_nxt    = ST_GI_SEL;
        end else if ((r_r == o_r) || (r_r == p_r)) begin
          r_nxt = r_r + idx_t'(1);
        end else begin
          ret_nxt = RET_G2;
          st_nxt  = ST_FRD1;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          ctl.out_last = (o_r == sts.n);
          if (o_r == sts.n) begin
            st_nxt = ST_IDLE;
          end else begin
            o_nxt  = o_r + idx_t'(1);
            st_nxt = ST_GJ_INIT;
          end
        end
      end
      ST_FRD1: begin
        st_nxt = ST_FRD2;
      end
      ST_FRD2: begin
        ctl.rd_addr = t_sel;
        ctl.hold_en = 1'b1;
        st_nxt      = ST_FGO;
      end
      ST_FGO: begin
        ctl.q_go    = 1'b1;
        ctl.use_one = (ret_r == RET_G1);
        st_nxt      = ST_FWAIT;
      end
      ST_FWAIT: begin
        if (sts.div_done) begin
          st_nxt = ST_FM1;
        end
      end
      ST_FM1: begin
        ctl.mul_go = 1'b1;
        st_nxt     = ST_FM2;
      end
      ST_FM2: begin
        st_nxt = ST_FM3;
      end
      ST_FM3: begin
        ctl.acc_ld = 1'b1;
        case (ret_r)
          RET_SH: begin
            p_nxt  = p_r + idx_t'(1);
            st_nxt = ST_SH_SEL;
          end
          RET_G1: begin
            r_nxt  = '0;
            st_nxt = ST_GR_SEL;
          end
          default: begin
            r_nxt  = r_r + idx_t'(1);
            st_nxt = ST_GR_SEL;
          end
        endcase
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      o_r   <= '0;
      p_r   <= '0;
      r_r   <= '0;
      ret_r <= RET_SH;
    end else begin
      st_r  <= st_nxt;
      o_r   <= o_nxt;
      p_r   <= p_nxt;
      r_r   <= r_nxt;
      ret_r <= ret_nxt;
    end
  end
endmodule

>>> src/lbe_datapath.sv
module lbe_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lbe_pkg::ctl_t               ctl,
  output lbe_pkg::sts_t               sts,
  input  logic [lbe_pkg::ORDER_W-1:0] cfg_order,
  input  lbe_pkg::value_t             cfg_left,
  input  lbe_pkg::value_t             cfg_right,
  input  lbe_pkg::idx_t               in_node_index,
  input  lbe_pkg::value_t             in_nodal_value,
  input  lbe_pkg::value_t             in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lbe_pkg::idx_t               out_node_number,
  output lbe_pkg::value_t             out_shape_value,
  output lbe_pkg::value_t             out_shape_gradient,
  output lbe_pkg::value_t             out_interpolated,
  output logic                        out_bad_interval,
  output logic                        out_last
);
  import lbe_pkg::*;

  localparam int PROD_W = 2 * VALUE_W;
  localparam logic [DIV_NUM_W-1:0]     QPOS_LIM = DIV_NUM_W'(VAL_MAX);
  localparam logic [DIV_NUM_W-1:0]     QNEG_LIM = QPOS_LIM + DIV_NUM_W'(1);
  localparam logic signed [PROD_W-1:0] RND      = (PROD_W'(1) <<< FRAC_W) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] PMAX     = PROD_W'(VAL_MAX);
  localparam logic signed [PROD_W-1:0] PMIN     = PROD_W'(VAL_MIN);

  value_t                    a_r, x_r, hold_r, rdata_r, acc_r, qres_r, msat_r, g_r, interp_r;
  logic [VALUE_W-1:0]        span_r;
  idx_t                      n_r;
  value_t                    xs_mem  [NODES];
  value_t                    store_r [NODES];
  value_t                    shp_r   [NODES];
  logic signed [PROD_W-1:0]  prod_r;
  logic                      neg_r, pzero_r, dzero_r, psign_r;

  value_t                    lo, hi;
  logic signed [VALUE_W:0]   span_w;
  idx_t                      n_eff;
  logic signed [VALUE_W:0]   pdiff, ddiff, pmag, dmag;
  logic [VALUE_W+IDX_W-1:0]  nprod;
  logic                      div_go, div_done;
  logic [DIV_NUM_W-1:0]      div_num, div_quo;
  logic [DIV_DEN_W-1:0]      div_den;
  value_t                    qsat, mop, node_x, msat;
  logic [VALUE_W-1:0]        qneg;
  logic signed [PROD_W-1:0]  prod_rnd, prod_sh;

  logic   out_valid_r;
  idx_t   out_node_r;
  value_t out_shape_r, out_grad_r, out_interp_r;
  logic   out_bad_r, out_last_r;

  always_comb begin
    lo     = (cfg_right < cfg_left) ? cfg_right : cfg_left;
    hi     = (cfg_right < cfg_left) ? cfg_left : cfg_right;
    span_w = {hi[VALUE_W-1], hi} - {lo[VALUE_W-1], lo};
    if (cfg_order == '0) begin
      n_eff = idx_t'(1);
    end else if (cfg_order > ORDER_W'(MAX_ORDER)) begin
      n_eff = idx_t'(MAX_ORDER);
    end else begin
      n_eff = idx_t'(cfg_order);
    end

    pdiff = ctl.use_one ? {ONE_Q[VALUE_W-1], ONE_Q}
                        : {x_r[VALUE_W-1], x_r} - {rdata_r[VALUE_W-1], rdata_r};
    ddiff = {hold_r[VALUE_W-1], hold_r} - {rdata_r[VALUE_W-1], rdata_r};
    pmag  = pdiff[VALUE_W] ? -pdiff : pdiff;
    dmag  = ddiff[VALUE_W] ? -ddiff : ddiff;
    nprod = span_r * ctl.idx;

    div_go  = ctl.node_go | ctl.q_go;
    div_num = ctl.node_go ? DIV_NUM_W'(nprod) : {pmag[VALUE_W-1:0], {FRAC_W{1'b0}}};
    div_den = ctl.node_go ? DIV_DEN_W'(n_r) : dmag[VALUE_W-1:0];

    // Sign and saturation of a quotient; a zero divisor with a nonzero dividend gives
    // the extreme value with the sign of the dividend.
    qneg = '0 - div_quo[VALUE_W-1:0];
    if (pzero_r) begin
      qsat = '0;
    end else if (dzero_r) begin
      qsat = psign_r ? VAL_MIN : VAL_MAX;
    end else if (!neg_r) begin
      qsat = (div_quo > QPOS_LIM) ? VAL_MAX : value_t'(div_quo[VALUE_W-1:0]);
    end else begin
      qsat = (div_quo > QNEG_LIM) ? VAL_MIN : value_t'(qneg);
    end

    node_x = a_r + value_t'(div_quo[VALUE_W-1:0]);
    mop    = ctl.mul_nodal ? store_r[ctl.idx] : qres_r;

    // Product rescale, truncating toward zero.
    prod_rnd = prod_r + (prod_r[PROD_W-1] ? RND : PROD_W'(0));
    prod_sh  = prod_rnd >>> FRAC_W;
    if (prod_sh > PMAX) begin
      msat = VAL_MAX;
    end else if (prod_sh < PMIN) begin
      msat = VAL_MIN;
    end else begin
      msat = value_t'(prod_sh[VALUE_W-1:0]);
    end
  end

  lbe_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r      <= in_position;
      a_r      <= lo;
      span_r   <= span_w[VALUE_W-1:0];
      n_r      <= n_eff;
      interp_r <= '0;
    end else if (ctl.interp_add) begin
      interp_r <= sat_sum({interp_r[VALUE_W-1], interp_r} + {msat_r[VALUE_W-1], msat_r});
    end
    rdata_r <= xs_mem[ctl.rd_addr];
    if (ctl.hold_en) begin
      hold_r <= rdata_r;
    end
    if (ctl.node_wr) begin
      xs_mem[ctl.idx] <= node_x;
    end
    if (ctl.q_go) begin
      neg_r   <= pdiff[VALUE_W] ^ ddiff[VALUE_W];
      psign_r <= pdiff[VALUE_W];
      pzero_r <= (pdiff == '0);
      dzero_r <= (ddiff == '0);
    end
    if (div_done) begin
      qres_r <= qsat;
    end
    if (ctl.acc_one) begin
      acc_r <= ONE_Q;
    end else if (ctl.acc_ld) begin
      acc_r <= msat_r;
    end
    if (ctl.mul_go) begin
      prod_r <= acc_r * mop;
    end
    msat_r <= msat;
    if (ctl.g_clr) begin
      g_r <= '0;
    end else if (ctl.g_add) begin
      g_r <= sat_sum({g_r[VALUE_W-1], g_r} + {acc_r[VALUE_W-1], acc_r});
    end
    if (ctl.shp_wr) begin
      shp_r[ctl.idx] <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < NODES; e++) begin
        store_r[e] <= '0;
      end
    end else if (ctl.store && (in_node_index < idx_t'(NODES))) begin
      store_r[in_node_index] <= in_nodal_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_bad_r  <= ctl.out_bad;
      out_last_r <= ctl.out_last;
      if (ctl.out_bad) begin
        out_node_r   <= '0;
        out_shape_r  <= '0;
        out_grad_r   <= '0;
        out_interp_r <= '0;
      end else begin
        out_node_r   <= ctl.idx;
        out_shape_r  <= shp_r[ctl.idx];
        out_grad_r   <= g_r;
        out_interp_r <= ctl.out_last ? interp_r : '0;
      end
    end
  end

  always_comb begin
    sts.div_done = div_done;
    sts.bad      = (cfg_left == cfg_right);
    sts.n        = n_r;
    sts.out_busy = out_valid_r & ~out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_node_number    = out_node_r;
  assign out_shape_value    = out_shape_r;
  assign out_shape_gradient = out_grad_r;
  assign out_interpolated   = out_interp_r;
  assign out_bad_interval   = out_bad_r;
  assign out_last           = out_last_r;
endmodule

>>> src/lagrange_basis_evaluator_unit.sv
// Channel   Dir  Beat contents
// in_ch     in   mode, node_index, nodal_value, position
// out_ch    out  node_number, shape_value, shape_gradient, interpolated, bad_interval, last
// cfg_*     in   write enable, register index, write data (no read-back)
//
// A load beat is taken directly in the idle state. A query beat first places the
// n+1 nodes, one 48-step division each, then runs n*(n+1)*(n+1) quotient-times-product
// factors through the single shared divider and multiplier; the serial divider
// dominates the run time.
// Reset is synchronous and active low; it restores the register defaults and
// clears the nodal store. A waiting result sits in the output register while work
// on the next node continues; the controller only stalls when it must load it again.
module lagrange_basis_evaluator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lbe_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lbe_pkg::VALUE_W-1:0]   cfg_wdata,
  lbe_in_if.sink                        in_ch,
  lbe_out_if.source                     out_ch
);
  import lbe_pkg::*;

  // Configuration registers. The order is clamped and the ends are sorted in the
  // datapath at the start of each query.
  logic [ORDER_W-1:0] order_r;
  value_t             left_r;
  value_t             right_r;

  ctl_t ctl;
  sts_t sts;
  logic in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_W'(1);
      left_r  <= '0;
      right_r <= ONE_Q;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ORDER: order_r <= cfg_wdata[ORDER_W-1:0];
        CFG_LEFT:  left_r  <= value_t'(cfg_wdata);
        CFG_RIGHT: right_r <= value_t'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // The controller sequences node placement, the shape products, the gradient
  // sums and the result beats; the datapath holds every value.
  lbe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_mode (in_ch.mode),
    .in_ready(in_ready),
    .ctl     (ctl),
    .sts     (sts)
  );

  lbe_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .cfg_order         (order_r),
    .cfg_left          (left_r),
    .cfg_right         (right_r),
    .in_node_index     (in_ch.node_index),
    .in_nodal_value    (in_ch.nodal_value),
    .in_position       (in_ch.position),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_node_number   (out_ch.node_number),
    .out_shape_value   (out_ch.shape_value),
    .out_shape_gradient(out_ch.shape_gradient),
    .out_interpolated  (out_ch.interpolated),
    .out_bad_interval  (out_ch.bad_interval),
    .out_last          (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  // A result waiting to be taken is never overwritten.
  assert property (@(posedge clk) disable iff (!rst_n) ctl.out_load |-> !sts.out_busy)
    else $error("result register reloaded while its beat was still pending");

  // Every new result beat comes from a load by the controller.
  assert property (@(posedge clk) disable iff (!rst_n)
                   $rose(out_ch.valid) |-> $past(ctl.out_load))
    else $error("result valid rose without a load");

  // An interval error is a single, final, all-zero beat.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_ch.valid && out_ch.bad_interval |->
                   out_ch.last && (out_ch.node_number == '0) && (out_ch.shape_value == '0))
    else $error("bad interval beat carries data");

  // The last beat of a good query belongs to the highest node.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_ch.valid && out_ch.last && !out_ch.bad_interval |->
                   out_ch.node_number == sts.n)
    else $error("last beat not on the final node");
endmodule

>>> sim/lbe_checker.sv
`timescale 1ns / 1ps

module lbe_checker
  import lbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [VALUE_W-1:0]   cfg_wdata,
  lbe_in_if                    in_ch,
  lbe_out_if                   out_ch,
  output int                   mismatches,
  output int                   waiting,
  output int                   checked
);

  typedef struct {
    idx_t   node;
    value_t shape;
    value_t grad;
    value_t interp;
    logic   bad;
    logic   last;
  } basis_beat_t;

  basis_beat_t        basis_q[$];
  logic [ORDER_W-1:0] order_reg;
  longint             end_l;
  longint             end_r;
  longint             nodal_mem[NODES];

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint QONE = 64'sd65536;

  function automatic longint clamp(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint qmul(input longint u, input longint v);
    return clamp((u * v) / QONE);
  endfunction

  // A zero divisor arises only when nodes coincide on a very short interval.
  function automatic longint qdiv(input longint p, input longint d);
    if (d == 0) return (p > 0) ? QMAX : ((p < 0) ? QMIN : 0);
    return clamp((p * QONE) / d);
  endfunction

  task automatic predict_basis(input longint x);
    longint      xs[NODES];
    longint      shp[NODES];
    longint      lo, hi, span, acc, t, g;
    int          n;
    basis_beat_t r;
    if (end_l == end_r) begin
      r = '{node: '0, shape: '0, grad: '0, interp: '0, bad: 1'b1, last: 1'b1};
      basis_q = {basis_q, r};
      return;
    end
    lo = (end_r < end_l) ? end_r : end_l;
    hi = (end_r < end_l) ? end_l : end_r;
    n = int'(order_reg);
    if (n < 1) n = 1;
    if (n > MAX_ORDER) n = MAX_ORDER;
    span = hi - lo;
    for (int k = 0; k <= n; k++) xs[k] = lo + (span * k) / n;
    acc = 0;
    for (int i = 0; i <= n; i++) begin
      t = QONE;
      for (int j = 0; j <= n; j++)
        if (j != i) t = qmul(t, qdiv(x - xs[j], xs[i] - xs[j]));
      shp[i] = t;
      acc = clamp(acc + qmul(t, nodal_mem[i]));
    end
    for (int j = 0; j <= n; j++) begin
      g = 0;
      for (int i = 0; i <= n; i++) begin
        if (i == j) continue;
        t = qdiv(QONE, xs[j] - xs[i]);
        for (int m = 0; m <= n; m++)
          if (m != i && m != j) t = qmul(t, qdiv(x - xs[m], xs[j] - xs[m]));
        g = clamp(g + t);
      end
      r.node   = idx_t'(j);
      r.shape  = value_t'(shp[j]);
      r.grad   = value_t'(g);
      r.interp = (j == n) ? value_t'(acc) : '0;
      r.bad    = 1'b0;
      r.last   = (j == n);
      basis_q = {basis_q, r};
    end
  endtask

  task automatic report(input string field, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0d, got %0d", field, want, got);
  endtask

  initial begin
    mismatches = 0;
    waiting    = 0;
    checked    = 0;
  end

  always @(posedge clk) begin
    basis_beat_t e;
    if (!rst_n) begin
      order_reg = 4'd1;
      end_l     = 0;
      end_r     = QONE;
      foreach (nodal_mem[k]) nodal_mem[k] = 0;
      basis_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (basis_q.size() == 0) begin
          report("unexpected beat, node", -1, out_ch.node_number);
        end else begin
          e = basis_q.pop_front();
          if (out_ch.node_number !== e.node) report("node_number", e.node, out_ch.node_number);
          if (out_ch.shape_value !== e.shape)
            report("shape_value", e.shape, out_ch.shape_value);
          if (out_ch.shape_gradient !== e.grad)
            report("shape_gradient", e.grad, out_ch.shape_gradient);
          if (out_ch.interpolated !== e.interp)
            report("interpolated", e.interp, out_ch.interpolated);
          if (out_ch.bad_interval !== e.bad) report("bad_interval", e.bad, out_ch.bad_interval);
          if (out_ch.last !== e.last) report("last", e.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == 1'b0) begin
          if (in_ch.node_index < NODES)
            nodal_mem[in_ch.node_index] = longint'($signed(in_ch.nodal_value));
        end else begin
          predict_basis(longint'($signed(in_ch.position)));
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ORDER: order_reg = cfg_wdata[ORDER_W-1:0];
          CFG_LEFT:  end_l = longint'($signed(cfg_wdata));
          CFG_RIGHT: end_r = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
    end
    waiting = basis_q.size();
  end

endmodule

>>> sim/tb_lagrange_basis_evaluator_unit.sv
`timescale 1ns / 1ps

module tb_lagrange_basis_evaluator_unit;
  import lbe_pkg::*;

  localparam int     HOLD_CYCLES = 3000;
  localparam longint QONE        = 64'sd65536;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [VALUE_W-1:0]   cfg_wdata;

  lbe_in_if  in_ch ();
  lbe_out_if out_ch ();

  int mismatches;
  int waiting;
  int checked;

  // Stimulus bookkeeping. The calm flag switches off all idling for the tail of the
  // run, and hold_req asks the receiver for one long stall.
  int  beats_sent;
  int  n_query;
  int  n_load;
  bit  calm;
  bit  hold_req;
  bit  offering;

  // The ends currently programmed, sorted, so that positions can be aimed inside.
  longint span_lo;
  longint span_hi;

  lagrange_basis_evaluator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  lbe_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mismatches(mismatches),
    .waiting   (waiting),
    .checked   (checked)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The limit leaves room for a handful of order-8 queries on top of the random
  // phases and every stall.
  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // The receiver mostly accepts, drops ready in short random bursts, and once holds
  // off for a long stretch so that results back up into the block and stall its input.
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one beat and waits for the edge where it is taken. Valid stays high when
  // the next beat follows straight on; otherwise it drops for a random gap before the task returns.
  task automatic put(input logic m, input idx_t i, input value_t v, input value_t p);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.node_index  <= i;
    in_ch.nodal_value <= v;
    in_ch.position    <= p;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (m) n_query++;
    else n_load++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic load(input idx_t i, input value_t v);
    put(1'b0, i, v, value_t'($urandom));
  endtask

  task automatic query(input value_t p);
    put(1'b1, idx_t'($urandom), value_t'($urandom), p);
  endtask

  // Waits until every expected result has been seen, then a little longer so that a
  // trailing load has certainly been absorbed before the registers change.
  task automatic drain();
    if (offering) in_ch.valid <= 1'b0;
    offering = 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input logic [ORDER_W-1:0] ord, input value_t l, input value_t r);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ORDER;
    cfg_wdata <= VALUE_W'(ord);
    @(posedge clk);
    cfg_idx   <= CFG_LEFT;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_idx   <= CFG_RIGHT;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    span_lo = ($signed(l) < $signed(r)) ? longint'(l) : longint'(r);
    span_hi = ($signed(l) < $signed(r)) ? longint'(r) : longint'(l);
  endtask

  function automatic value_t clip(input longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return value_t'(v);
  endfunction

  // Positions mostly fall inside the interval, with some at the ends, some just
  // outside and some anywhere in the full range.
  function automatic value_t pick_position();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5)
      return clip(span_lo + ((span_hi - span_lo) * $urandom_range(0, 1024)) / 1024);
    if (sel == 6) return clip($urandom_range(0, 1) ? span_lo : span_hi);
    if (sel == 9) return clip(span_lo - longint'($urandom_range(0, 4 * 65536)));
    return value_t'($urandom);
  endfunction

  function automatic value_t pick_end();
    if ($urandom_range(0, 3) == 0) return value_t'($urandom);
    return clip(longint'($urandom_range(0, 16 * 65536)) - 8 * QONE);
  endfunction

  // One random phase: new settings, the nodal store filled in node order, then a
  // mix of queries and further loads. Slow orders get at most one query.
  task automatic random_phase();
    logic [ORDER_W-1:0] ord;
    value_t             l, r;
    int                 sel, eff, qcap, nitems;
    sel = $urandom_range(0, 19);
    if (sel == 0) ord = 4'd0;
    else if (sel <= 9) ord = 4'd1;
    else if (sel <= 15) ord = 4'd2;
    else if (sel <= 17) ord = 4'd3;
    else if (sel == 18) ord = 4'd4;
    else ord = ORDER_W'($urandom_range(5, 15));
    eff = (ord == 0) ? 1 : ((ord > MAX_ORDER) ? MAX_ORDER : int'(ord));
    qcap = (eff >= 5) ? 1 : ((eff >= 3) ? 4 : 10);

    l = pick_end();
    sel = $urandom_range(0, 9);
    if (sel == 0) r = l;                                     // equal ends
    else if (sel == 1) r = clip(longint'(l) + $urandom_range(0, 10));   // coincident nodes
    else r = pick_end();
    set_config(ord, l, r);

    nitems = $urandom_range(10, 18);
    for (int k = 0; k <= eff && nitems > 0; k++, nitems--)
      load(idx_t'(k), value_t'($urandom));
    while (nitems > 0) begin
      nitems--;
      if (qcap > 0 && $urandom_range(0, 9) < 7) begin
        qcap--;
        query(pick_position());
      end else begin
        load(idx_t'($urandom), value_t'($urandom));
      end
      if (beats_sent >= 265) calm = 1'b1;
    end
  endtask

  initial begin
    beats_sent = 0;
    n_query    = 0;
    n_load     = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    offering   = 1'b0;
    span_lo    = 0;
    span_hi    = QONE;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_ORDER;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = 1'b0;
    in_ch.node_index  = '0;
    in_ch.nodal_value = '0;
    in_ch.position    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings: order one on [0, 1.0]. Extreme nodal values, loads to indices
    // beyond the store which must be ignored, and positions at the extremes.
    load(4'd0, VAL_MAX);
    load(4'd1, VAL_MIN);
    load(4'd9, value_t'(32'h1234_5678));
    load(4'd15, VAL_MAX);
    query(value_t'(0));
    query(ONE_Q);
    query(value_t'(32'sh8000));
    query(VAL_MAX);
    query(VAL_MIN);
    query(value_t'(-1));

    // Highest order on [-4.0, 4.0].
    set_config(4'd8, clip(-4 * QONE), clip(4 * QONE));
    load(4'd8, ONE_Q);
    load(4'd4, clip(-2 * QONE));
    query(value_t'(32'sh8000));
    query(clip(4 * QONE));

    // Order zero acts as one; the ends arrive reversed and are swapped.
    set_config(4'd0, clip(3 * QONE), clip(-QONE));
    query(value_t'(0));
    query(clip(5 * QONE));

    // An order above the maximum acts as the maximum, across the full range.
    set_config(4'd15, VAL_MIN, VAL_MAX);
    query(value_t'(0));

    // Equal ends give a single flagged result; a load in between changes nothing.
    set_config(4'd2, clip(2 * QONE), clip(2 * QONE));
    query(value_t'(0));
    load(4'd2, value_t'(32'h0003_0000));
    query(clip(2 * QONE));

    // An interval shorter than the node count makes nodes coincide.
    set_config(4'd4, value_t'(0), value_t'(2));
    query(value_t'(1));
    query(value_t'(0));

    // Reversed extremes as ends.
    set_config(4'd2, VAL_MAX, VAL_MIN);
    query(VAL_MAX);

    // Back pressure: the receiver stalls for a long stretch while queries keep
    // coming, so that the output backs up and the block refuses input.
    set_config(4'd1, value_t'(0), ONE_Q);
    hold_req = 1'b1;
    repeat (8) query(pick_position());

    while (beats_sent < 310) random_phase();

    drain();
    repeat (50) @(posedge clk);
    $display("Run covered %0d load beats and %0d query beats; %0d result beats checked.",
             n_load, n_query, checked);
    $display("Orders zero to fifteen, swapped, equal and coincident ends, and a long stall.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
